// ----- sv/dkee_pkg.sv -----
// shared types and constants for the keypad entry editor
// no dependencies; used by dkee_step and decimal_keypad_entry_editor
`timescale 1ns / 1ps

package dkee_pkg;

  // key event codes
  typedef enum logic [2:0] {
    REQ_DIGIT  = 3'd0,
    REQ_POINT  = 3'd1,
    REQ_SIGN   = 3'd2,
    REQ_EXP    = 3'd3,
    REQ_BACK   = 3'd4,
    REQ_ENTER  = 3'd5,
    REQ_COMMIT = 3'd6,
    REQ_DROP   = 3'd7
  } req_t;

  // requests to the stack side on x
  typedef enum logic [1:0] {
    XA_NONE   = 2'd0,
    XA_NEGATE = 2'd1,
    XA_CLEAR  = 2'd2
  } xact_t;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned COUNT_W = 4;          // width of digit_count and point_pos fields
  localparam int unsigned IN_W    = 8;          // s_tdata width
  localparam int unsigned CTL_BITS = 6;         // flag bits packed into m_tdata besides fields
  localparam logic [3:0]  DIGIT_MAX = 4'd9;

  // editor flags kept between events
  typedef struct packed {
    logic started;
    logic after_enter;
    logic neg;
    logic in_exp;
    logic exp_neg;
  } flags_t;

  // stack-side requests of one result
  typedef struct packed {
    logic  push_zero;
    logic  clear_error;
    xact_t x_action;
    logic  commit_valid;
  } ctl_t;

  // flag part of the entry snapshot
  typedef struct packed {
    logic entry_active;
    logic mant_negative;
    logic exp_mode;
    logic exp_negative;
  } snap_t;

endpackage

// ----- sv/dkee_step.sv -----
// per-key editing logic: next entry state, stack requests and snapshot
// depends on dkee_pkg
`timescale 1ns / 1ps

module dkee_step #(
  parameter int unsigned MANT_DIGITS = 10,
  parameter int unsigned EXP_DIGITS  = 3,
  localparam int unsigned CW = $clog2(MANT_DIGITS + 1),
  localparam int unsigned MW = 4 * MANT_DIGITS,
  localparam int unsigned EW = 4 * EXP_DIGITS
) (
  input  dkee_pkg::req_t   req,
  input  logic [3:0]       digit_in,
  input  logic             err,
  input  dkee_pkg::flags_t flags_q,
  input  logic [MW-1:0]    mant_q,
  input  logic [CW-1:0]    count_q,
  input  logic [CW-1:0]    point_q,
  input  logic [EW-1:0]    exp_q,
  output dkee_pkg::flags_t flags_d,
  output logic [MW-1:0]    mant_d,
  output logic [CW-1:0]    count_d,
  output logic [CW-1:0]    point_d,
  output logic [EW-1:0]    exp_d,
  output dkee_pkg::ctl_t   ctl,
  output dkee_pkg::snap_t  snap,
  output logic [MW-1:0]    snap_mant,
  output logic [CW-1:0]    snap_count,
  output logic [CW-1:0]    snap_point,
  output logic [EW-1:0]    snap_exp
);

  logic [3:0] d;
  logic       opens;
  logic       leading_zero;
  logic       lone_zero;

  assign d = (digit_in > dkee_pkg::DIGIT_MAX) ? dkee_pkg::DIGIT_MAX : digit_in;
  assign opens = !flags_q.started &&
                 (req inside {dkee_pkg::REQ_DIGIT, dkee_pkg::REQ_POINT, dkee_pkg::REQ_EXP});
  assign leading_zero = (d == 4'd0) && (point_q == '0) && (count_q == '0);
  assign lone_zero = (count_q == CW'(1)) && (mant_q[3:0] == 4'd0);

  always_comb begin
    flags_d = flags_q;
    mant_d  = mant_q;
    count_d = count_q;
    point_d = point_q;
    exp_d   = exp_q;
    ctl     = '0;
    ctl.x_action = dkee_pkg::XA_NONE;

    // first key of an entry
    if (opens) begin
      ctl.push_zero       = !flags_q.after_enter && !err;
      ctl.clear_error     = 1'b1;
      flags_d.started     = 1'b1;
      flags_d.after_enter = 1'b0;
    end

    case (req)
      dkee_pkg::REQ_DIGIT: begin
        if (!flags_q.in_exp) begin
          if (count_q < CW'(MANT_DIGITS) && !leading_zero) begin
            for (int i = 0; i < MANT_DIGITS; i++) begin
              if (CW'(i) == count_q) begin
                mant_d[4*i +: 4] = d;
              end
            end
            count_d = count_q + 1'b1;
          end
        end else begin
          exp_d = (exp_q << 4) | EW'(d);
        end
      end
      dkee_pkg::REQ_POINT: begin
        if (!flags_q.in_exp && point_q == '0) begin
          if (count_q == '0) begin
            mant_d[3:0] = 4'd0;
            count_d     = CW'(1);
            point_d     = CW'(1);
          end else begin
            point_d = count_q;
          end
        end
      end
      dkee_pkg::REQ_SIGN: begin
        if (flags_q.started) begin
          if (!flags_q.in_exp) begin
            flags_d.neg = !flags_q.neg;
          end else begin
            flags_d.exp_neg = !flags_q.exp_neg;
          end
        end else if (!err) begin
          ctl.x_action = dkee_pkg::XA_NEGATE;
        end
      end
      dkee_pkg::REQ_EXP: begin
        // empty or lone zero mantissa turns into a one
        if (count_q == '0 || lone_zero) begin
          mant_d[3:0] = 4'd1;
          count_d     = CW'(1);
        end
        flags_d.in_exp = 1'b1;
      end
      dkee_pkg::REQ_BACK: begin
        if (flags_q.started) begin
          if (!flags_q.in_exp) begin
            if (count_q != '0) begin
              if (point_q != '0 && point_q >= count_q) begin
                point_d = '0;
              end else begin
                count_d = count_q - 1'b1;
                if (count_q == CW'(1)) begin
                  flags_d.neg = 1'b0;
                end
              end
            end else begin
              flags_d.neg = 1'b0;
            end
          end else if (exp_q == '0) begin
            flags_d.in_exp = 1'b0;
          end else begin
            exp_d = exp_q >> 4;
            if ((exp_q >> 4) == '0) begin
              flags_d.exp_neg = 1'b0;
            end
          end
        end else begin
          ctl.clear_error = 1'b1;
          ctl.x_action    = dkee_pkg::XA_CLEAR;
        end
      end
      dkee_pkg::REQ_ENTER, dkee_pkg::REQ_COMMIT: begin
        if (flags_q.started) begin
          ctl.commit_valid = 1'b1;
          flags_d = '0;
          mant_d  = '0;
          count_d = '0;
          point_d = '0;
          exp_d   = '0;
        end
        if (!err) begin
          flags_d.after_enter = (req == dkee_pkg::REQ_ENTER);
        end
      end
      default: begin
        // drop or clear
        ctl.clear_error = 1'b1;
        flags_d = '0;
        mant_d  = '0;
        count_d = '0;
        point_d = '0;
        exp_d   = '0;
      end
    endcase
  end

  // snapshot: entry before a commit, otherwise entry after the key
  always_comb begin
    if (ctl.commit_valid) begin
      snap.entry_active  = 1'b0;
      snap.mant_negative = flags_q.neg;
      snap.exp_mode      = flags_q.in_exp;
      snap.exp_negative  = flags_q.exp_neg;
      snap_count         = count_q;
      snap_point         = point_q;
      snap_exp           = exp_q;
      for (int i = 0; i < MANT_DIGITS; i++) begin
        snap_mant[4*i +: 4] = (CW'(i) < count_q) ? mant_q[4*i +: 4] : 4'd0;
      end
    end else begin
      snap.entry_active  = flags_d.started;
      snap.mant_negative = flags_d.neg;
      snap.exp_mode      = flags_d.in_exp;
      snap.exp_negative  = flags_d.exp_neg;
      snap_count         = count_d;
      snap_point         = point_d;
      snap_exp           = exp_d;
      for (int i = 0; i < MANT_DIGITS; i++) begin
        snap_mant[4*i +: 4] = (CW'(i) < count_d) ? mant_d[4*i +: 4] : 4'd0;
      end
    end
  end

endmodule

// ----- sv/decimal_keypad_entry_editor.sv -----
// top level of the keypad number-entry editor: input register, editing logic, result register
// depends on dkee_pkg and dkee_step
// a key passes the input register, then the result register, which offers its result
// throughput: one key transaction per cycle unless a held result stalls intake; entry state
//   moves as the key leaves the input register, so consecutive keys see each other's edits
// reset: synchronous active-high rst empties both registers and clears the entry state
`timescale 1ns / 1ps

module decimal_keypad_entry_editor #(
  parameter int unsigned MANT_DIGITS = 10,
  parameter int unsigned EXP_DIGITS  = 3,
  localparam int unsigned MW       = 4 * MANT_DIGITS,
  localparam int unsigned EW       = 4 * EXP_DIGITS,
  localparam int unsigned OUT_BITS = dkee_pkg::CTL_BITS + MW + 2 * dkee_pkg::COUNT_W + 1 + EW + 1,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // key transactions
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dkee_pkg::IN_W-1:0]  s_tdata,  // digit[3:0], error_pending[4], zero pad
  input  logic [dkee_pkg::REQ_W-1:0] s_tuser,  // req_type
  // result transactions
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_W-1:0]           m_tdata,  // push_zero, clear_error, x_action[2],
                                               // entry_active, mant_negative, mant_digits,
                                               // digit_count[4], point_pos[4], exp_mode,
                                               // exp_digits, exp_negative, zero pad
  output logic                       m_tuser   // commit_valid
);

  localparam int unsigned CW = $clog2(MANT_DIGITS + 1);

  // input register
  logic             in_valid;
  dkee_pkg::req_t   in_req;
  logic [3:0]       in_digit;
  logic             in_err;

  // entry state
  dkee_pkg::flags_t flags;
  logic [MW-1:0]    mant;
  logic [CW-1:0]    count;
  logic [CW-1:0]    point;
  logic [EW-1:0]    expo;

  // next state from the editing logic
  dkee_pkg::flags_t flags_next;
  logic [MW-1:0]    mant_next;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    point_next;
  logic [EW-1:0]    expo_next;

  // result of the key in the input register
  dkee_pkg::ctl_t   ctl;
  dkee_pkg::snap_t  snap;
  logic [MW-1:0]    snap_mant;
  logic [CW-1:0]    snap_count;
  logic [CW-1:0]    snap_point;
  logic [EW-1:0]    snap_exp;

  // result register
  logic             out_valid;
  dkee_pkg::ctl_t   out_ctl;
  dkee_pkg::snap_t  out_snap;
  logic [MW-1:0]    out_mant;
  logic [CW-1:0]    out_count;
  logic [CW-1:0]    out_point;
  logic [EW-1:0]    out_exp;

  logic advance;  // result register can take a new result
  logic fire;     // key in the input register is processed this cycle

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  // input register refills as it drains; a held result stalls intake once it is full
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_req   <= dkee_pkg::req_t'(s_tuser);
      in_digit <= s_tdata[3:0];
      in_err   <= s_tdata[4];
    end
  end

  dkee_step #(
    .MANT_DIGITS (MANT_DIGITS),
    .EXP_DIGITS  (EXP_DIGITS)
  ) u_step (
    .req        (in_req),
    .digit_in   (in_digit),
    .err        (in_err),
    .flags_q    (flags),
    .mant_q     (mant),
    .count_q    (count),
    .point_q    (point),
    .exp_q      (expo),
    .flags_d    (flags_next),
    .mant_d     (mant_next),
    .count_d    (count_next),
    .point_d    (point_next),
    .exp_d      (expo_next),
    .ctl        (ctl),
    .snap       (snap),
    .snap_mant  (snap_mant),
    .snap_count (snap_count),
    .snap_point (snap_point),
    .snap_exp   (snap_exp)
  );

  // entry state moves once per processed key
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      mant  <= '0;
      count <= '0;
      point <= '0;
      expo  <= '0;
    end else if (fire) begin
      flags <= flags_next;
      mant  <= mant_next;
      count <= count_next;
      point <= point_next;
      expo  <= expo_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (fire) begin
      out_ctl   <= ctl;
      out_snap  <= snap;
      out_mant  <= snap_mant;
      out_count <= snap_count;
      out_point <= snap_point;
      out_exp   <= snap_exp;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_ctl.commit_valid;
  assign m_tdata  = OUT_W'({out_snap.exp_negative,
                            out_exp,
                            out_snap.exp_mode,
                            dkee_pkg::COUNT_W'(out_point),
                            dkee_pkg::COUNT_W'(out_count),
                            out_mant,
                            out_snap.mant_negative,
                            out_snap.entry_active,
                            out_ctl.x_action,
                            out_ctl.clear_error,
                            out_ctl.push_zero});

  // a processed key always lands in the result register
  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed key did not produce a result");

  // a commit leaves no entry behind
  a_commit_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && ctl.commit_valid) |=> (!flags.started && count == '0 && point == '0))
    else $error("entry state not cleared after commit");

  // point never sits past the stored digits
  a_point_in_range: assert property (@(posedge clk) disable iff (rst)
    fire |=> (point <= count && count <= CW'(MANT_DIGITS)))
    else $error("point or digit count out of range");

endmodule
